/* design/assert_macros.svh */
// assertion macros shared by the bank mapper modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge outside reset
`define BMRTC_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequence must hold in the same cycle as the antecedent
`define BMRTC_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequence must hold in the cycle after the antecedent
`define BMRTC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/bmrtc_pkg.sv */
// types and constants of the bank mapper with real time clock
`default_nettype none

package bmrtc_pkg;

   // request operation codes
   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   // address regions, top three address bits
   localparam logic [2:0] REGION_RAM_EN   = 3'd0;
   localparam logic [2:0] REGION_ROM_PAGE = 3'd1;
   localparam logic [2:0] REGION_RAM_PAGE = 3'd2;
   localparam logic [2:0] REGION_LATCH    = 3'd3;
   localparam logic [2:0] REGION_EXT_RAM  = 3'd5;

   // rtc register select codes
   localparam logic [7:0] SEL_SECONDS = 8'h08;
   localparam logic [7:0] SEL_MINUTES = 8'h09;
   localparam logic [7:0] SEL_HOURS   = 8'h0A;
   localparam logic [7:0] SEL_DAYS_LO = 8'h0B;
   localparam logic [7:0] SEL_CONTROL = 8'h0C;

   // csr register indexes
   localparam logic [1:0] CSR_RTC_PRESENT   = 2'd0;
   localparam logic [1:0] CSR_ROM_PAGE_MASK = 2'd1;
   localparam logic [1:0] CSR_RAM_PAGE_MAX  = 2'd2;

   // misc constants
   localparam logic [7:0] RAM_ENABLE_KEY = 8'h0A;
   localparam logic [7:0] LATCH_KEY      = 8'h01;
   localparam logic [7:0] SECONDS_LIMIT  = 8'd60;
   localparam logic [7:0] MINUTES_LIMIT  = 8'd60;
   localparam logic [7:0] HOURS_LIMIT    = 8'd24;
   localparam logic [8:0] DAYS_LAST      = 9'd511;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] address;
      logic [7:0]  data;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       rtc_hit;
      logic [6:0] rom_page;
      logic [1:0] ram_page;
      logic       ram_enabled;
      logic       rtc_mapped;
   } rsp_type;

   typedef struct packed {
      logic       rtc_present;
      logic [6:0] rom_page_mask;
      logic [1:0] ram_page_max;
   } cfg_type;

   // bank mapping state
   typedef struct packed {
      logic       ram_enable;
      logic [6:0] rom_page;
      logic [1:0] ram_page;
      logic       rtc_window;
      logic [7:0] rtc_select;
   } map_type;

   // commands from the mapper to the clock
   typedef struct packed {
      logic       tick;
      logic       latch;
      logic       rtc_write;
      logic [7:0] sel;
      logic [7:0] data;
   } cmd_type;

   // one snapshot of the clock
   typedef struct packed {
      logic [7:0] seconds;
      logic [7:0] minutes;
      logic [7:0] hours;
      logic [8:0] days;
      logic       halt;
      logic       carry;
   } time_type;

endpackage

`default_nettype wire

/* design/bank_mapper_with_rtc.sv */
// top level of the bank mapper with real time clock
//
//   port group   dir   handshake           payload
//   req_         in    req_valid/req_stall  req_payload (op, address, data)
//   rsp_         out   rsp_valid/rsp_stall  rsp_payload (read_data .. rtc_mapped)
//   csr_         in    csr_valid/csr_ready  csr_index, csr_wdata
//
// one request per cycle while req_stall is low; each request goes from acceptance to result
// through the input register, then decode and state update into the result register
// a stalled result holds the result register; the input register still fills,
// and req_stall rises only when both registers are full
// reset is synchronous; csr writes are always ready
`default_nettype none
`include "assert_macros.svh"

module bank_mapper_with_rtc (
   input  wire                logic       clock,
   input  wire                logic       reset,
   input  wire                logic       req_valid,
   output                     logic       req_stall,
   input  wire bmrtc_pkg::req_type        req_payload,
   output                     logic       rsp_valid,
   input  wire                logic       rsp_stall,
   output      bmrtc_pkg::rsp_type        rsp_payload,
   input  wire                logic       csr_valid,
   output                     logic       csr_ready,
   input  wire                logic [1:0] csr_index,
   input  wire                logic [7:0] csr_wdata
);
   import bmrtc_pkg::*;

   logic       req_valid_ff;
   req_type    req_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   rsp_type    rsp_ff;
   rsp_type    rsp_in;
   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       advance;
   logic       fire;
   logic       req_take;
   logic       rtc_hit;
   map_type    map_cur;
   map_type    map_nxt;
   cmd_type    cmd;
   logic [7:0] lat_data;

   // pipeline control
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = req_valid_ff && advance;
   assign req_stall = req_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   // csr registers
   assign csr_ready = 1'b1;
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_RTC_PRESENT:   cfg_in.rtc_present   = csr_wdata[0];
            CSR_ROM_PAGE_MASK: cfg_in.rom_page_mask = csr_wdata[6:0];
            CSR_RAM_PAGE_MAX:  cfg_in.ram_page_max  = csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   bmrtc_map u_map (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .req     (req_ff),
      .cfg     (cfg_ff),
      .map_cur (map_cur),
      .map_nxt (map_nxt),
      .cmd     (cmd)
   );

   bmrtc_clock u_clock (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .lat_data (lat_data)
   );

   // read answered by the rtc window
   assign rtc_hit = (req_ff.op == OP_READ) && (req_ff.address[15:13] == REGION_EXT_RAM) &&
                    cfg_ff.rtc_present && map_cur.rtc_window &&
                    (map_cur.rtc_select >= SEL_SECONDS) && (map_cur.rtc_select <= SEL_CONTROL);

   // result assembly
   always_comb begin
      rsp_in.read_data   = rtc_hit ? lat_data : 8'd0;
      rsp_in.rtc_hit     = rtc_hit;
      rsp_in.rom_page    = map_nxt.rom_page & cfg_ff.rom_page_mask;
      rsp_in.ram_page    = map_nxt.ram_page;
      rsp_in.ram_enabled = map_nxt.ram_enable;
      rsp_in.rtc_mapped  = map_nxt.rtc_window & cfg_ff.rtc_present;
   end

   assign rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff       <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         cfg_ff.rtc_present   <= 1'b1;
         cfg_ff.rom_page_mask <= 7'h7F;
         cfg_ff.ram_page_max  <= 2'd3;
      end else begin
         req_valid_ff <= req_take || req_stall;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_payload;
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `BMRTC_ASSERT_IMPLIES(a_stall_full, req_stall, req_valid_ff && rsp_valid_ff,
      "request stalled with a free register")
   `BMRTC_ASSERT_IMPLIES(a_hit_mapped, rsp_valid_ff && rsp_ff.rtc_hit, rsp_ff.rtc_mapped,
      "rtc hit without rtc window")
   `BMRTC_ASSERT_IMPLIES(a_hit_read, fire && (req_ff.op != OP_READ), !rsp_in.rtc_hit,
      "rtc hit on a non-read request")

endmodule

`default_nettype wire

/* design/bmrtc_map.sv */
// bank mapping registers and request decode
`default_nettype none
`include "assert_macros.svh"

module bmrtc_map (
   input  wire                logic     clock,
   input  wire                logic     reset,
   input  wire                logic     fire,
   input  wire bmrtc_pkg::req_type      req,
   input  wire bmrtc_pkg::cfg_type      cfg,
   output      bmrtc_pkg::map_type      map_cur,
   output      bmrtc_pkg::map_type      map_nxt,
   output      bmrtc_pkg::cmd_type      cmd
);
   import bmrtc_pkg::*;

   map_type    map_ff;
   map_type    map_in;
   logic [2:0] region;
   logic       is_write;
   logic       rtc_code;
   logic [1:0] bank_req;

   assign region   = req.address[15:13];
   assign is_write = fire && (req.op == OP_WRITE);
   assign rtc_code = (req.data >= SEL_SECONDS) && (req.data <= SEL_CONTROL);
   assign bank_req = req.data[1:0];

   // next mapping state from bus writes
   always_comb begin
      map_in = map_ff;
      if (is_write) begin
         unique case (region)
            REGION_RAM_EN: begin
               map_in.ram_enable = ((req.data & RAM_ENABLE_KEY) == RAM_ENABLE_KEY);
            end
            REGION_ROM_PAGE: begin
               map_in.rom_page = (req.data[6:0] == 7'd0) ? 7'd1 : req.data[6:0];
            end
            REGION_RAM_PAGE: begin
               if (cfg.rtc_present && rtc_code) begin
                  map_in.rtc_window = 1'b1;
                  map_in.rtc_select = req.data;
               end else begin
                  map_in.rtc_window = 1'b0;
                  if (cfg.ram_page_max != 2'd0) begin
                     map_in.ram_page = (bank_req > cfg.ram_page_max) ?
                                       cfg.ram_page_max : bank_req;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // commands for the clock
   always_comb begin
      cmd.tick      = fire && (req.op == OP_TICK);
      cmd.latch     = is_write && (region == REGION_LATCH) && (req.data == LATCH_KEY);
      cmd.rtc_write = is_write && (region == REGION_EXT_RAM) && map_ff.ram_enable &&
                      cfg.rtc_present && map_ff.rtc_window;
      cmd.sel       = map_ff.rtc_select;
      cmd.data      = req.data;
   end

   // mapping registers
   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff.ram_enable <= 1'b0;
         map_ff.rom_page   <= 7'd1;
         map_ff.ram_page   <= 2'd0;
         map_ff.rtc_window <= 1'b0;
         map_ff.rtc_select <= 8'd0;
      end else begin
         map_ff <= map_in;
      end
   end

   assign map_cur = map_ff;
   assign map_nxt = map_in;

   `BMRTC_ASSERT_ALWAYS(a_rom_page_nonzero, map_ff.rom_page != 7'd0, "rom page register is zero")
   `BMRTC_ASSERT_IMPLIES(a_window_select, map_ff.rtc_window,
      (map_ff.rtc_select >= SEL_SECONDS) && (map_ff.rtc_select <= SEL_CONTROL),
      "rtc window open with bad select")

endmodule

`default_nettype wire

/* design/bmrtc_clock.sv */
// real time clock counters, latch copy and latched register read
`default_nettype none
`include "assert_macros.svh"

module bmrtc_clock (
   input  wire                logic       clock,
   input  wire                logic       reset,
   input  wire bmrtc_pkg::cmd_type        cmd,
   output      logic [7:0]                lat_data
);
   import bmrtc_pkg::*;

   time_type   now_ff;
   time_type   now_in;
   time_type   lat_ff;
   time_type   lat_in;
   logic [7:0] sec_inc;
   logic [7:0] min_inc;
   logic [7:0] hr_inc;

   assign sec_inc = now_ff.seconds + 8'd1;
   assign min_inc = now_ff.minutes + 8'd1;
   assign hr_inc  = now_ff.hours + 8'd1;

   // counter update on ticks and register writes
   always_comb begin
      now_in = now_ff;
      if (cmd.tick && !now_ff.halt) begin
         if (sec_inc == SECONDS_LIMIT) begin
            now_in.seconds = 8'd0;
            if (min_inc == MINUTES_LIMIT) begin
               now_in.minutes = 8'd0;
               if (hr_inc == HOURS_LIMIT) begin
                  now_in.hours = 8'd0;
                  if (now_ff.days == DAYS_LAST) begin
                     now_in.days  = 9'd0;
                     now_in.carry = 1'b1;
                  end else begin
                     now_in.days = now_ff.days + 9'd1;
                  end
               end else begin
                  now_in.hours = hr_inc;
               end
            end else begin
               now_in.minutes = min_inc;
            end
         end else begin
            now_in.seconds = sec_inc;
         end
      end else if (cmd.rtc_write) begin
         unique case (cmd.sel)
            SEL_SECONDS: now_in.seconds = cmd.data;
            SEL_MINUTES: now_in.minutes = cmd.data;
            SEL_HOURS:   now_in.hours   = cmd.data;
            SEL_DAYS_LO: now_in.days    = {now_ff.days[8], cmd.data};
            SEL_CONTROL: begin
               now_in.days  = {cmd.data[0], now_ff.days[7:0]};
               now_in.halt  = cmd.data[6];
               now_in.carry = cmd.data[7];
            end
            default: ;
         endcase
      end
   end

   // latch copy
   assign lat_in = cmd.latch ? now_ff : lat_ff;

   // latched register read
   always_comb begin
      unique case (cmd.sel)
         SEL_SECONDS: lat_data = lat_ff.seconds;
         SEL_MINUTES: lat_data = lat_ff.minutes;
         SEL_HOURS:   lat_data = lat_ff.hours;
         SEL_DAYS_LO: lat_data = lat_ff.days[7:0];
         SEL_CONTROL: lat_data = {lat_ff.carry, lat_ff.halt, 5'd0, lat_ff.days[8]};
         default:     lat_data = 8'd0;
      endcase
   end

   // clock and latch registers
   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff <= '0;
         lat_ff <= '0;
      end else begin
         now_ff <= now_in;
         lat_ff <= lat_in;
      end
   end

   `BMRTC_ASSERT_NEXT(a_seconds_wrap,
      cmd.tick && !now_ff.halt && (now_ff.seconds == SECONDS_LIMIT - 8'd1),
      now_ff.seconds == 8'd0, "seconds did not wrap")
   `BMRTC_ASSERT_NEXT(a_halt_freezes, cmd.tick && now_ff.halt, $stable(now_ff),
      "clock moved while halted")

endmodule

`default_nettype wire
